@@ hdl/atmg_pkg.sv @@
// ----------------------------------------------------------------------------
// atmg_pkg
// Shared types and constants for the axis tick marker generator.
// ----------------------------------------------------------------------------
package atmg_pkg;

    localparam int POS_W   = 48;
    localparam int SPACE_W = 47;
    localparam int TOTAL_W = 5;
    localparam int CNT_W   = 7;
    localparam int N_MULT  = 9;
    localparam int N_DEC   = 7;

    localparam logic [63:0] SPACING_MAX = 64'h0000_7FFF_FFFF_FFFF;

    localparam logic [63:0] DEC_POW [0:N_DEC-1] = '{
        64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000
    };

    localparam logic [63:0] NICE_MULT [0:N_MULT-1] = '{
        64'd1, 64'd2, 64'd5, 64'd10, 64'd20, 64'd50, 64'd100, 64'd200, 64'd500
    };

    typedef struct packed {
        logic signed [POS_W-1:0] range_low;
        logic signed [POS_W-1:0] range_high;
    } t_range_in;

    typedef struct packed {
        logic signed [POS_W-1:0] tick_position;
        logic [SPACE_W-1:0]      tick_spacing;
        logic [TOTAL_W-1:0]      tick_total;
        logic                    is_final;
    } t_tick_out;

    typedef struct packed {
        logic [POS_W-1:0]   start;
        logic [SPACE_W-1:0] step;
        logic [CNT_W-1:0]   cnt;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

@@ hdl/atmg_fifo.sv @@
// ----------------------------------------------------------------------------
// atmg_fifo
// Two-entry job queue between step selection and tick emission.
// ----------------------------------------------------------------------------
module atmg_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  atmg_pkg::t_job    i_data,
    input  logic              i_pop,
    output atmg_pkg::t_job    o_data,
    output atmg_pkg::t_fifo_stat o_stat
);

    atmg_pkg::t_job r_mem [0:1];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

endmodule

@@ hdl/atmg_front.sv @@
// ----------------------------------------------------------------------------
// atmg_front
// Takes a range, picks decade and nice step, finds start and tick count.
// ----------------------------------------------------------------------------
module atmg_front #(
    parameter int MAX_MARKERS   = 16,
    parameter int FRACTION_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  atmg_pkg::t_range_in  i_range,
    input  atmg_pkg::t_fifo_stat i_fifo,
    output logic                 o_busy,
    output logic                 o_push,
    output atmg_pkg::t_job       o_job
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXP  = 3'd1;
    localparam logic [2:0] S_CAND = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_PUSH = 3'd5;

    localparam logic [63:0] Unit     = 64'(100) << FRACTION_BITS;
    localparam int          DivIters = atmg_pkg::POS_W / 2;

    logic [63:0] w_lo_thr [0:atmg_pkg::N_DEC-1];
    logic [63:0] w_hi_thr [0:atmg_pkg::N_DEC-1];
    logic [atmg_pkg::SPACE_W-1:0] w_cand [0:12][0:atmg_pkg::N_MULT-1];

    genvar gk, ge, gj;
    generate
        for (gk = 0; gk < atmg_pkg::N_DEC; gk++) begin : g_thr
            localparam logic [63:0] LoT =
                (Unit + atmg_pkg::DEC_POW[gk] - 64'd1) / atmg_pkg::DEC_POW[gk];
            localparam logic [63:0] HiT = Unit * atmg_pkg::DEC_POW[gk];
            assign w_lo_thr[gk] = LoT;
            assign w_hi_thr[gk] = HiT;
        end
        for (ge = 0; ge < 13; ge++) begin : g_exp
            for (gj = 0; gj < atmg_pkg::N_MULT; gj++) begin : g_mult
                localparam int          Pi  = (ge >= 6) ? ge - 6 : 6 - ge;
                localparam logic [63:0] Num = atmg_pkg::NICE_MULT[gj] << FRACTION_BITS;
                localparam logic [63:0] Raw = (ge >= 6) ?
                    Num * atmg_pkg::DEC_POW[Pi] :
                    (Num + atmg_pkg::DEC_POW[Pi] / 64'd2) / atmg_pkg::DEC_POW[Pi];
                localparam logic [63:0] Val = (Raw < 64'd1) ? 64'd1 :
                    ((Raw > atmg_pkg::SPACING_MAX) ? atmg_pkg::SPACING_MAX : Raw);
                assign w_cand[ge][gj] = Val[atmg_pkg::SPACE_W-1:0];
            end
        end
    endgenerate

    logic [2:0]  r_state;
    logic        r_lo_neg;
    logic [47:0] r_alo;
    logic [48:0] r_len;
    logic [47:0] r_big;
    logic [3:0]  r_eidx;
    logic [3:0]  r_j;
    logic [46:0] r_step;
    logic [48:0] r_d3;
    logic        r_fit;
    logic [46:0] r_rem;
    logic [47:0] r_dvd;
    logic [4:0]  r_it;
    logic [49:0] r_acc;
    logic [atmg_pkg::CNT_W-1:0] r_cnt;

    logic signed [48:0] w_diff;
    logic [48:0] w_len;
    logic [47:0] w_alo;
    logic [47:0] w_ahi;
    logic [3:0]  n_eidx;
    logic [53:0] w_lim;
    logic        w_ok;
    logic [48:0] w_r4;
    logic [48:0] w_d1;
    logic [48:0] w_d2;
    logic [46:0] n_rem;
    logic        w_div_done;
    logic        w_cnt_run;
    logic [47:0] w_t;

    assign w_diff = 49'(i_range.range_high) - 49'(i_range.range_low);
    assign w_len  = w_diff[48] ? 49'(-w_diff) : 49'(w_diff);
    assign w_alo  = i_range.range_low[47]  ? 48'(-i_range.range_low)  : i_range.range_low;
    assign w_ahi  = i_range.range_high[47] ? 48'(-i_range.range_high) : i_range.range_high;

    always_comb begin
        n_eidx = 4'd0;
        if (64'(r_big) > Unit) begin
            n_eidx = 4'd12;
            for (int k = 6; k >= 1; k--) begin
                if (w_hi_thr[k] >= 64'(r_big)) begin
                    n_eidx = 4'(6 + k);
                end
            end
        end else begin
            for (int k = 6; k >= 0; k--) begin
                if (64'(r_big) >= w_lo_thr[k]) begin
                    n_eidx = 4'(6 - k);
                end
            end
        end
    end

    assign w_lim = 54'(r_step) * 54'(MAX_MARKERS);
    assign w_ok  = (54'(r_len) <= w_lim);

    assign w_r4 = {r_rem, r_dvd[47:46]};
    assign w_d1 = 49'(r_step);
    assign w_d2 = {1'b0, r_step, 1'b0};

    always_comb begin
        if (w_r4 >= r_d3) begin
            n_rem = 47'(w_r4 - r_d3);
        end else if (w_r4 >= w_d2) begin
            n_rem = 47'(w_r4 - w_d2);
        end else if (w_r4 >= w_d1) begin
            n_rem = 47'(w_r4 - w_d1);
        end else begin
            n_rem = 47'(w_r4);
        end
    end

    assign w_div_done = (r_it == 5'(DivIters));
    assign w_cnt_run  = r_fit && (r_acc < 50'(r_len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_lo_neg <= i_range.range_low[47];
                        r_alo    <= w_alo;
                        r_len    <= w_len;
                        r_big    <= (w_alo > w_ahi) ? w_alo : w_ahi;
                        r_state  <= S_EXP;
                    end
                end
                S_EXP: begin
                    r_eidx  <= n_eidx;
                    r_j     <= 4'd0;
                    r_state <= S_CAND;
                end
                S_CAND: begin
                    r_step  <= w_cand[r_eidx][r_j];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (w_ok || r_j == 4'(atmg_pkg::N_MULT - 1)) begin
                        r_fit   <= w_ok;
                        r_cnt   <= w_ok ? '0 : atmg_pkg::CNT_W'(MAX_MARKERS);
                        r_acc   <= '0;
                        r_rem   <= '0;
                        r_dvd   <= r_alo;
                        r_it    <= '0;
                        r_d3    <= 49'(r_step) + {1'b0, r_step, 1'b0};
                        r_state <= S_DIV;
                    end else begin
                        r_j     <= r_j + 4'd1;
                        r_state <= S_CAND;
                    end
                end
                S_DIV: begin
                    if (!w_div_done) begin
                        r_rem <= n_rem;
                        r_dvd <= {r_dvd[45:0], 2'b00};
                        r_it  <= r_it + 5'd1;
                    end
                    if (w_cnt_run) begin
                        r_acc <= r_acc + 50'(r_step);
                        r_cnt <= r_cnt + atmg_pkg::CNT_W'(1);
                    end
                    if (w_div_done && !w_cnt_run) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_fifo.full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_t = r_alo - 48'(r_rem);

    always_comb begin
        o_job.step = r_step;
        o_job.cnt  = r_cnt;
        if (r_cnt == '0) begin
            o_job.start = '0;
        end else if (r_lo_neg) begin
            o_job.start = 48'(48'd0 - w_t);
        end else begin
            o_job.start = w_t + 48'(r_step);
        end
    end

    assign o_push = (r_state == S_PUSH) && !i_fifo.full;
    assign o_busy = (r_state != S_IDLE);

endmodule

@@ hdl/atmg_back.sv @@
// ----------------------------------------------------------------------------
// atmg_back
// Emits one tick word per cycle for each queued job.
// ----------------------------------------------------------------------------
module atmg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  atmg_pkg::t_fifo_stat i_fifo,
    input  atmg_pkg::t_job       i_job,
    output logic                 o_pop,
    output logic                 o_strobe,
    output atmg_pkg::t_tick_out  o_result
);

    atmg_pkg::t_job             r_job;
    logic                       r_active;
    logic [atmg_pkg::CNT_W-1:0] r_idx;
    logic [47:0]                r_pos;
    logic                       r_strobe;
    atmg_pkg::t_tick_out        r_out;
    logic                       w_final;

    assign o_pop   = !r_active && !i_fifo.empty;
    assign w_final = (r_job.cnt == '0) ||
                     ((r_idx + atmg_pkg::CNT_W'(1)) == r_job.cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (o_pop) begin
                r_job    <= i_job;
                r_pos    <= i_job.start;
                r_idx    <= '0;
                r_active <= 1'b1;
            end
            if (r_active) begin
                r_out.tick_position <= r_pos;
                r_out.tick_spacing  <= r_job.step;
                r_out.tick_total    <= r_job.cnt[atmg_pkg::TOTAL_W-1:0];
                r_out.is_final      <= w_final;
                r_pos <= r_pos + 48'(r_job.step);
                r_idx <= r_idx + atmg_pkg::CNT_W'(1);
                if (w_final) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_spacing_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_out.tick_spacing != '0)
        else $error("zero tick spacing");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_out.is_final |=> r_strobe)
        else $error("tick run broken");

    a_position_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_out.is_final |=>
            r_out.tick_position == 48'($past(r_out.tick_position)
                                       + 48'($past(r_out.tick_spacing))))
        else $error("tick position not advanced by spacing");

    a_spacing_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe && !r_out.is_final |=> $stable(r_out.tick_spacing))
        else $error("spacing changed within run");

endmodule

@@ hdl/axis_tick_marker_generator.sv @@
// ----------------------------------------------------------------------------
// axis_tick_marker_generator
// Axis range in, run of 1-2-5 spaced tick positions out.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_range and raise start; the word is taken on an edge where busy
//   is low. The front stage picks the decade, tries the nice steps
//   (up to nine), then runs a radix-4 remainder unit alongside a tick
//   counter (one add per tick, at most MAX_MARKERS). The front takes one
//   range at a time: busy stays high until its job is pushed, which
//   waits while the queue is full. A two-entry queue feeds the back
//   stage, which puts out one tick word per cycle during each job's run
//   on o_result, flagged by o_strobe. The front takes the next range
//   while earlier ticks are still going out.
//   An empty axis gives a single word with total 0.
//   Results cannot be stalled: each word is valid for one cycle only.
//   Reset (i_rst_n low, synchronous) empties the queue and idles both stages.
// ----------------------------------------------------------------------------
module axis_tick_marker_generator #(
    parameter int MAX_MARKERS   = 16,
    parameter int FRACTION_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  atmg_pkg::t_range_in i_range,
    output logic                o_strobe,
    output atmg_pkg::t_tick_out o_result
);

    logic                 w_push;
    logic                 w_pop;
    atmg_pkg::t_job       w_job_in;
    atmg_pkg::t_job       w_job_out;
    atmg_pkg::t_fifo_stat w_stat;

    atmg_front #(
        .MAX_MARKERS   (MAX_MARKERS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_range (i_range),
        .i_fifo  (w_stat),
        .o_busy  (busy),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    atmg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_stat  (w_stat)
    );

    atmg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fifo   (w_stat),
        .i_job    (w_job_out),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

@@ dv/tb_axis_tick_marker_generator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_axis_tick_marker_generator
// Axis ranges in, expected 1-2-5 tick runs checked word by word.
// A behavioral predictor computes each tick run when a range is accepted.
// A monitor compares every strobed word against the oldest expected word.
// ----------------------------------------------------------------------------
module tb_axis_tick_marker_generator;

    localparam int MAX_TICKS = 16;
    localparam int FRAC      = 24;
    localparam int WD_LIMIT  = 4000;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    atmg_pkg::t_range_in i_range;
    logic                o_strobe;
    atmg_pkg::t_tick_out o_result;

    atmg_pkg::t_tick_out tick_queue[$];
    int        err_count;
    int        idle_count;
    int        send_gap;
    bit        timed_out;

    axis_tick_marker_generator #(.MAX_MARKERS(MAX_TICKS), .FRACTION_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_range(i_range), .o_strobe(o_strobe), .o_result(o_result)
    );

    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    function automatic logic [63:0] abs_of(input logic signed [63:0] s);
        return s < 0 ? 64'(-s) : 64'(s);
    endfunction

    function automatic int decade_of(input logic [63:0] big);
        logic [63:0] unit;
        unit = 64'd100 << FRAC;
        if (big > unit) begin
            for (int k = 1; k <= 6; k++)
                if (unit * atmg_pkg::DEC_POW[k] >= big) return k;
            return 6;
        end
        for (int k = 0; k <= 6; k++)
            if (big * atmg_pkg::DEC_POW[k] >= unit) return -k;
        return -6;
    endfunction

    function automatic logic [63:0] nice_step(input logic [63:0] m, input int e);
        logic [63:0] num, v, d;
        num = m << FRAC;
        if (e >= 0) begin
            v = num * atmg_pkg::DEC_POW[e];
        end else begin
            d = atmg_pkg::DEC_POW[-e];
            v = (num + d / 2) / d;
        end
        if (v < 1) v = 1;
        if (v > atmg_pkg::SPACING_MAX) v = atmg_pkg::SPACING_MAX;
        return v;
    endfunction

    task automatic predict_ticks(input atmg_pkg::t_range_in r);
        logic signed [63:0] lo, hi;
        logic [63:0] len, alo, ahi, step, cnt, first;
        int e;
        atmg_pkg::t_tick_out w;
        lo = 64'(r.range_low);
        hi = 64'(r.range_high);
        len = abs_of(hi - lo);
        alo = abs_of(lo);
        ahi = abs_of(hi);
        e = decade_of(alo > ahi ? alo : ahi);
        step = 0;
        cnt = 0;
        for (int i = 0; i < atmg_pkg::N_MULT; i++) begin
            step = nice_step(atmg_pkg::NICE_MULT[i], e);
            cnt = (len + step - 1) / step;
            if (cnt <= MAX_TICKS) break;
        end
        if (cnt > MAX_TICKS) cnt = MAX_TICKS;
        if (cnt == 0) begin
            w.tick_position = '0;
            w.tick_spacing  = step[atmg_pkg::SPACE_W-1:0];
            w.tick_total    = '0;
            w.is_final      = 1'b1;
            tick_queue = {tick_queue, w};
            return;
        end
        if (lo < 0) first = 64'd0 - (alo / step) * step;
        else first = alo + step - (alo % step);
        for (int i = 0; i < cnt; i++) begin
            w.tick_position = atmg_pkg::POS_W'(first + i * step);
            w.tick_spacing  = step[atmg_pkg::SPACE_W-1:0];
            w.tick_total    = cnt[atmg_pkg::TOTAL_W-1:0];
            w.is_final      = (i + 1 == cnt);
            tick_queue = {tick_queue, w};
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        atmg_pkg::t_tick_out want;
        if (i_rst_n && o_strobe) begin
            if (tick_queue.size() == 0) begin
                report_mismatch("unexpected word", 64'(o_result), 0);
            end else begin
                want = tick_queue.pop_front();
                if (o_result.tick_position !== want.tick_position)
                    report_mismatch("tick_position", 64'(o_result.tick_position),
                                    64'(want.tick_position));
                if (o_result.tick_spacing !== want.tick_spacing)
                    report_mismatch("tick_spacing", 64'(o_result.tick_spacing),
                                    64'(want.tick_spacing));
                if (o_result.tick_total !== want.tick_total)
                    report_mismatch("tick_total", 64'(o_result.tick_total),
                                    64'(want.tick_total));
                if (o_result.is_final !== want.is_final)
                    report_mismatch("is_final", 64'(o_result.is_final),
                                    64'(want.is_final));
            end
        end
    end

    // watchdog: count cycles with no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy)) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WD_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("[axis_tick_marker_generator] ERROR");
            $finish;
        end
    end

    task automatic send_range(input logic signed [47:0] lo, input logic signed [47:0] hi);
        while (send_gap > 0 && $urandom_range(99) < send_gap) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_range.range_low  <= lo;
        i_range.range_high <= hi;
        do @(posedge i_clk); while (busy);
        predict_ticks('{range_low: lo, range_high: hi});
        @(negedge i_clk);
    endtask

    task automatic drain_ticks();
        start <= 1'b0;
        while (tick_queue.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic signed [47:0] rand_pos(input int scale);
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        case (scale)
            0: return $signed(v);
            1: return $signed(48'(v[39:0])) - 48'sd2 ** 39;
            2: return $signed(48'(v[33:0])) - 48'sd2 ** 33;
            default: return $signed(48'(v[27:0])) - 48'sd2 ** 27;
        endcase
    endfunction

    task automatic test_directed();
        logic signed [47:0] mx, mn, one;
        mx = 48'sh7FFF_FFFF_FFFF;
        mn = 48'sh8000_0000_0000;
        one = 48'sd1 << FRAC;
        send_range(0, 0);
        send_range(one, one);
        send_range(0, 10 * one);
        send_range(-10 * one, 10 * one);
        send_range(10 * one, -10 * one);
        send_range(mn, mx);
        send_range(mx, mn);
        send_range(mn, mn);
        send_range(mx, mx);
        send_range(0, 1);
        send_range(-1, 1);
        send_range(-one / 2, one / 3);
        send_range(100 * one, 100 * one + 5);
        send_range(100 * one + 1, 200 * one);
        send_range(-100 * one, 7 * one);
        send_range(mx - one, mx);
        send_range(mn, mn + one);
        send_range(-48'sd5, 48'sd3);
        send_range(5 * one, 20 * one);
        send_range(-20 * one, -5 * one);
        drain_ticks();
    endtask

    task automatic test_random(input int n);
        logic signed [47:0] lo, hi;
        for (int i = 0; i < n; i++) begin
            lo = rand_pos($urandom_range(3));
            if ($urandom_range(9) < 7) hi = lo + (rand_pos($urandom_range(1, 3)) >>> 2);
            else hi = rand_pos($urandom_range(3));
            send_range(lo, hi);
        end
    endtask

    initial begin
        send_gap   = 0;
        start      = 1'b0;
        i_range    = '0;
        i_rst_n    = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        send_gap = 34;
        test_random(30);
        drain_ticks();
        send_gap = 88;
        test_random(25);
        send_gap = 0;
        test_random(30);
        drain_ticks();
        if (err_count == 0 && tick_queue.size() == 0) begin
            $display("[axis_tick_marker_generator] OK");
        end else begin
            $display("[axis_tick_marker_generator] ERROR");
        end
        $finish;
    end

endmodule

@@ axis_tick_marker_generator.f @@
hdl/atmg_pkg.sv
hdl/atmg_fifo.sv
hdl/atmg_front.sv
hdl/atmg_back.sv
hdl/axis_tick_marker_generator.sv
dv/tb_axis_tick_marker_generator.sv
